/* design/rtea_pkg.sv */
// Shared types, constants and the RTEA half-round mixing function.
// Used by the controller, the datapath and the top level of the RTEA cipher block.
package rtea_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned RoundW    = $clog2(NumRounds);
  localparam int unsigned BlockW    = 64;
  localparam int unsigned WordW     = 32;
  localparam int unsigned NumKeys   = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned ModeW     = 3;

  localparam logic [RoundW-1:0] LastRound = RoundW'(NumRounds - 1);

  // Chaining mode codes; the unused codes behave as ECB.
  localparam logic [ModeW-1:0] MODE_ECB  = 3'd0;
  localparam logic [ModeW-1:0] MODE_CBC  = 3'd1;
  localparam logic [ModeW-1:0] MODE_PCBC = 3'd2;
  localparam logic [ModeW-1:0] MODE_CFB  = 3'd3;
  localparam logic [ModeW-1:0] MODE_OFB  = 3'd4;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_KEY01 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY23 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY45 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY67 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_MODE  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_DEC   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IV    = 3'd6;

  typedef struct packed {
    logic [NumKeys-1:0][WordW-1:0] key;
    logic [ModeW-1:0]              mode;
    logic                          dec;
    logic [BlockW-1:0]             iv;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic              load;    // capture a new input beat
    logic              step;    // run one half-round
    logic [RoundW-1:0] count;   // half-round counter, always counting up
    logic              finish;  // apply the mode and write the result register
  } dp_cmd_t;

  function automatic logic [WordW-1:0] rtea_mix(input logic [WordW-1:0]  x,
                                                input logic [RoundW-1:0] r,
                                                input logic [WordW-1:0]  k);
    logic [WordW-1:0] t;
    t = (x << 6) ^ (x >> 8);
    return x + t + k + WordW'(r);
  endfunction

endpackage

/* design/rtea_ctrl.sv */
// Controller state machine of the RTEA cipher block: handshakes and round count.
// Depends on rtea_pkg; drives the command struct of rtea_dp.
module rtea_ctrl import rtea_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [RoundW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    cmd_o        = '0;
    cmd_o.count  = cnt_q;
    in_ready_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + RoundW'(1);
        if (cnt_q == LastRound) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/rtea_dp.sv */
// Datapath of the RTEA cipher block: cipher halves, chaining vector and result register.
// Depends on rtea_pkg; steered by the command struct from rtea_ctrl.
module rtea_dp import rtea_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  dp_cmd_t           cmd_i,
  input  logic [BlockW-1:0] data_i,
  input  logic              first_i,
  output logic [BlockW-1:0] result_o
);

  logic [WordW-1:0]  a_q, b_q, a_d, b_d;
  logic [BlockW-1:0] x_q, chain_q, chain_d, res_q, res_d;
  logic [BlockW-1:0] v_start, core_in, core_out;
  logic              use_dec;
  logic [RoundW-1:0] rnd;
  logic [WordW-1:0]  mix_in, mix_out, upd;

  // Key-stream modes always run the cipher forward.
  assign use_dec = cfg_i.dec && (cfg_i.mode != MODE_CFB) && (cfg_i.mode != MODE_OFB);
  assign v_start = first_i ? cfg_i.iv : chain_q;
  assign core_out = {b_q, a_q};

  // Block chaining mixes the vector in before encryption and after decryption.
  always_comb begin
    case (cfg_i.mode)
      MODE_CBC, MODE_PCBC: core_in = use_dec ? data_i : (data_i ^ v_start);
      MODE_CFB, MODE_OFB:  core_in = v_start;
      default:             core_in = data_i;
    endcase
  end

  // Decryption walks the rounds backward, so the round number is the inverted count.
  assign rnd     = use_dec ? ~cmd_i.count : cmd_i.count;
  assign mix_in  = rnd[0] ? a_q : b_q;
  assign mix_out = rtea_mix(mix_in, rnd, cfg_i.key[rnd[2:0]]);
  assign upd     = rnd[0] ? b_q : a_q;

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    if (cmd_i.load) begin
      a_d = core_in[WordW-1:0];
      b_d = core_in[BlockW-1:WordW];
    end else if (cmd_i.step) begin
      if (rnd[0]) begin
        b_d = use_dec ? (upd - mix_out) : (upd + mix_out);
      end else begin
        a_d = use_dec ? (upd - mix_out) : (upd + mix_out);
      end
    end
  end

  // Mode post-processing once all half-rounds are done.
  always_comb begin
    res_d   = res_q;
    chain_d = chain_q;
    if (cmd_i.load) begin
      chain_d = v_start;
    end else if (cmd_i.finish) begin
      case (cfg_i.mode)
        MODE_CBC: begin
          if (use_dec) begin
            res_d   = core_out ^ chain_q;
            chain_d = x_q;
          end else begin
            res_d   = core_out;
            chain_d = core_out;
          end
        end
        MODE_PCBC: begin
          res_d   = use_dec ? (core_out ^ chain_q) : core_out;
          chain_d = res_d ^ x_q;
        end
        MODE_CFB: begin
          res_d   = x_q ^ core_out;
          chain_d = cfg_i.dec ? x_q : res_d;
        end
        MODE_OFB: begin
          res_d   = x_q ^ core_out;
          chain_d = core_out;
        end
        default: begin
          res_d = core_out;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    res_q <= res_d;
    if (cmd_i.load) begin
      x_q <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= '0;
    end else begin
      chain_q <= chain_d;
    end
  end

  assign result_o = res_q;

endmodule

/* design/rtea256_block_cipher_modes.sv */
// RTEA cipher (64-bit block, 256-bit key) with ECB, CBC, PCBC, CFB and OFB modes.
// The single half-round unit runs the 64 half-rounds one per cycle, between a load step on the
// accepted input beat and a finish step that waits for the output to be free; a new input beat
// is taken only after the previous block has been written to the result register.
// Reset (rst_ni, asynchronous, active low) clears the configuration registers, the
// chaining vector and the control state; the output holds no beat after reset.
module rtea256_block_cipher_modes import rtea_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [BlockW-1:0]  cfg_data_i,
  // Input stream.
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [BlockW-1:0]  s_axis_tdata_i,  // [63:0] data_block
  input  logic               s_axis_tuser_i,  // [0] first_block
  // Output stream.
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [BlockW-1:0]  m_axis_tdata_o   // [63:0] result_block
);

  // Configuration registers. The key pairs are held as eight 32-bit words;
  // word 2i comes from the low half of register i and word 2i+1 from its
  // high half. Index seven is ignored.
  cfg_t    cfg_q;
  dp_cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_KEY01: begin
          cfg_q.key[0] <= cfg_data_i[WordW-1:0];
          cfg_q.key[1] <= cfg_data_i[BlockW-1:WordW];
        end
        REG_KEY23: begin
          cfg_q.key[2] <= cfg_data_i[WordW-1:0];
          cfg_q.key[3] <= cfg_data_i[BlockW-1:WordW];
        end
        REG_KEY45: begin
          cfg_q.key[4] <= cfg_data_i[WordW-1:0];
          cfg_q.key[5] <= cfg_data_i[BlockW-1:WordW];
        end
        REG_KEY67: begin
          cfg_q.key[6] <= cfg_data_i[WordW-1:0];
          cfg_q.key[7] <= cfg_data_i[BlockW-1:WordW];
        end
        REG_MODE: cfg_q.mode <= cfg_data_i[ModeW-1:0];
        REG_DEC:  cfg_q.dec  <= cfg_data_i[0];
        REG_IV:   cfg_q.iv   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // The controller sequences load, 64 half-rounds and the finish step, and
  // holds the output beat until the sink takes it.
  rtea_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the cipher halves, the chaining vector and the
  // result register that drives the output beat.
  rtea_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .cmd_i    (cmd),
    .data_i   (s_axis_tdata_i),
    .first_i  (s_axis_tuser_i),
    .result_o (m_axis_tdata_o)
  );

endmodule
